[hdl/hcbd_pkg.sv]
`default_nettype none

package hcbd_pkg;

   // Decoder phase: size line, payload bytes, trailing skip, message done.
   typedef enum logic [3:0] {
      PH_LINE = 4'b0001,
      PH_DATA = 4'b0010,
      PH_SKIP = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   // What the size line looks like so far.
   typedef enum logic [2:0] {
      SHAPE_EMPTY = 3'b001,
      SHAPE_ZERO  = 3'b010,
      SHAPE_OTHER = 3'b100
   } shape_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_message;
   } req_word_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_end;
   } rsp_word_type;

   localparam logic [7:0] CHAR_CR   = 8'h0d;
   localparam logic [7:0] CHAR_LF   = 8'h0a;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   // Number of bytes skipped after each chunk's payload.
   localparam logic [1:0] TRAIL_BYTES = 2'd2;

   // Returns {is_hex, value} for one ASCII character.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'b0_0000;
   endfunction

endpackage

`default_nettype wire

[hdl/http_chunked_body_decoder.sv]
// A payload or end word for a taken byte is registered in the output buffer that drives rsp_.
// One byte per cycle while req_stall is low; the per-byte state update is combinational.
// A two-entry output buffer lets bytes keep flowing while one result waits on rsp_stall.
// Reset (synchronous, active high) returns to the start of a size line and empties
// the output buffer; new_message on a byte does the same to the decoder state.
`default_nettype none

module http_chunked_body_decoder #(
   parameter int SIZE_BITS = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  hcbd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output hcbd_pkg::rsp_word_type rsp_word
);

   typedef struct packed {
      logic [SIZE_BITS-1:0] acc;
      logic                 open;
      hcbd_pkg::shape_type  shape;
   } line_type;

   localparam line_type LINE_START = '{acc: '0, open: 1'b1, shape: hcbd_pkg::SHAPE_EMPTY};

   // Adds one ordinary size-line character: tracks the shape, accumulates hex
   // digits until the first non-hex one, and saturates on overflow.
   function automatic line_type line_char(input line_type s, input logic [7:0] c);
      line_type   r;
      logic [4:0] h;
      r = s;
      h = hcbd_pkg::hex_digit(c);
      if (s.shape == hcbd_pkg::SHAPE_EMPTY && c == hcbd_pkg::CHAR_ZERO) begin
         r.shape = hcbd_pkg::SHAPE_ZERO;
      end else begin
         r.shape = hcbd_pkg::SHAPE_OTHER;
      end
      if (s.open) begin
         if (!h[4]) begin
            r.open = 1'b0;
         end else if (s.acc[SIZE_BITS-1 -: 4] != 4'd0) begin
            r.acc = '1;
         end else begin
            r.acc = {s.acc[SIZE_BITS-5:0], h[3:0]};
         end
      end
      return r;
   endfunction

   hcbd_pkg::phase_type  phase_ff, phase_in;
   line_type             line_ff, line_in;
   logic                 pending_cr_ff, pending_cr_in;
   logic [SIZE_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [1:0]           skip_left_ff, skip_left_in;

   hcbd_pkg::rsp_word_type main_word_ff, main_word_in, skid_word_ff, skid_word_in;
   logic                   main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;

   logic                   req_accept;
   logic                   rsp_pop;
   logic                   res_valid;
   hcbd_pkg::rsp_word_type res_word;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = main_valid_ff;
   assign rsp_word   = main_word_ff;
   assign rsp_pop    = main_valid_ff && !rsp_stall;

   // Per-byte decoder step; new_message first returns the state to a fresh line.
   always_comb begin
      hcbd_pkg::phase_type  cur_phase;
      line_type             cur_line;
      logic                 cur_pending;
      logic [SIZE_BITS-1:0] cur_bytes;
      logic [1:0]           cur_skip;
      line_type             ln;
      logic [7:0]           c;

      c = req_word.data_byte;
      if (req_word.new_message) begin
         cur_phase   = hcbd_pkg::PH_LINE;
         cur_line    = LINE_START;
         cur_pending = 1'b0;
         cur_bytes   = '0;
         cur_skip    = 2'd0;
      end else begin
         cur_phase   = phase_ff;
         cur_line    = line_ff;
         cur_pending = pending_cr_ff;
         cur_bytes   = bytes_left_ff;
         cur_skip    = skip_left_ff;
      end

      phase_in      = cur_phase;
      line_in       = cur_line;
      pending_cr_in = cur_pending;
      bytes_left_in = cur_bytes;
      skip_left_in  = cur_skip;
      res_valid     = 1'b0;
      res_word      = '0;
      ln            = cur_line;

      case (cur_phase)
         hcbd_pkg::PH_LINE: begin
            if (cur_pending && c == hcbd_pkg::CHAR_LF) begin
               pending_cr_in = 1'b0;
               if (cur_line.shape == hcbd_pkg::SHAPE_ZERO) begin
                  phase_in        = hcbd_pkg::PH_DONE;
                  res_valid       = 1'b1;
                  res_word.is_end = 1'b1;
               end else begin
                  bytes_left_in = cur_line.acc;
                  if (cur_line.acc == '0) begin
                     phase_in     = hcbd_pkg::PH_SKIP;
                     skip_left_in = hcbd_pkg::TRAIL_BYTES;
                  end else begin
                     phase_in = hcbd_pkg::PH_DATA;
                  end
               end
            end else begin
               // A CR not followed by LF is an ordinary line character.
               if (cur_pending) begin
                  ln = line_char(ln, hcbd_pkg::CHAR_CR);
               end
               if (c == hcbd_pkg::CHAR_CR) begin
                  pending_cr_in = 1'b1;
               end else begin
                  pending_cr_in = 1'b0;
                  ln = line_char(ln, c);
               end
               line_in = ln;
            end
         end
         hcbd_pkg::PH_DATA: begin
            bytes_left_in         = cur_bytes - SIZE_BITS'(1);
            res_valid             = 1'b1;
            res_word.payload_byte = c;
            if (cur_bytes == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
               phase_in     = hcbd_pkg::PH_SKIP;
               skip_left_in = hcbd_pkg::TRAIL_BYTES;
            end
         end
         hcbd_pkg::PH_SKIP: begin
            skip_left_in = cur_skip - 2'd1;
            if (skip_left_in == 2'd0) begin
               phase_in      = hcbd_pkg::PH_LINE;
               line_in       = LINE_START;
               pending_cr_in = 1'b0;
               bytes_left_in = '0;
            end
         end
         hcbd_pkg::PH_DONE: begin
            phase_in = hcbd_pkg::PH_DONE;
         end
         default: begin
            phase_in = hcbd_pkg::PH_LINE;
         end
      endcase
   end

   // Output buffer: main register drives rsp_, the skid entry catches one word
   // that arrives while the main register is stalled.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_word_in  = main_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            main_valid_in = 1'b1;
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else begin
         if (!main_valid_ff || rsp_pop) begin
            main_valid_in = req_accept && res_valid;
            main_word_in  = res_word;
         end else if (req_accept && res_valid) begin
            skid_valid_in = 1'b1;
            skid_word_in  = res_word;
         end
      end
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hcbd_pkg::PH_LINE;
         line_ff       <= LINE_START;
         pending_cr_ff <= 1'b0;
         bytes_left_ff <= '0;
         skip_left_ff  <= 2'd0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         line_ff       <= line_in;
         pending_cr_ff <= pending_cr_in;
         bytes_left_ff <= bytes_left_in;
         skip_left_ff  <= skip_left_in;
      end
   end

   // Output buffer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   // The skid entry only fills behind a full main register.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a word while the main register is empty");

   // A skid word moves up as soon as the main word is taken.
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff && main_valid_ff)
      else $error("skid word was not moved into the main register");

   // Payload phase always has at least one byte left to forward.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hcbd_pkg::PH_DATA) |-> (bytes_left_ff != '0))
      else $error("payload phase with no bytes left");

   // Skip phase always has a trailing byte left to drop.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hcbd_pkg::PH_SKIP) |-> (skip_left_ff != 2'd0))
      else $error("skip phase with no bytes left to skip");

endmodule

`default_nettype wire

[bench/tb_http_chunked_body_decoder.sv]
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;

   localparam int N_DIRECTED     = 31;
   localparam int RANDOM_ITEMS   = 1020;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 10;
   localparam logic [31:0] SIZE_ALL_ONES = '1;

   // How a stimulus word's outcome is checked.
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_WORD
   } check_mode_type;

   typedef struct packed {
      hcbd_pkg::req_word_type word;
      check_mode_type         mode;
      hcbd_pkg::rsp_word_type fixed_word;
   } stim_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   hcbd_pkg::req_word_type req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   hcbd_pkg::rsp_word_type rsp_word;

   // Decoder state as the predictor sees it.
   hcbd_pkg::phase_type dec_phase;
   logic [31:0]         size_acc;
   bit                  digits_open;
   hcbd_pkg::shape_type line_shape;
   bit                  pending_cr;
   logic [31:0]         bytes_left;
   logic [1:0]          skip_left;

   hcbd_pkg::rsp_word_type awaited_words[$];
   hcbd_pkg::req_word_type msg_words[$];
   hcbd_pkg::req_word_type tail_words[$];
   stim_row_type           directed_rows[N_DIRECTED];
   hcbd_pkg::rsp_word_type want;
   int                     error_count = 0;
   int                     idle_cycles = 0;
   int                     hold_requests = 0;

   http_chunked_body_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5ns clock = ~clock;

   // Predictor: one size line, payload and trailing-skip decoder.
   function automatic void restart_line();
      dec_phase   = hcbd_pkg::PH_LINE;
      size_acc    = '0;
      digits_open = 1'b1;
      line_shape  = hcbd_pkg::SHAPE_EMPTY;
      pending_cr  = 1'b0;
   endfunction

   function automatic void clear_decoder();
      restart_line();
      bytes_left = '0;
      skip_left  = '0;
   endfunction

   function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
         v = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         v = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         v = 4'(c - "A" + 8'd10);
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // An ordinary size-line character: update the line shape and the size accumulator.
   function automatic void add_line_char(input logic [7:0] c);
      logic [3:0]  v;
      logic [31:0] v32;
      bit          is_hex;
      is_hex = hex_nibble(c, v);
      v32 = {28'd0, v};
      line_shape = (line_shape == hcbd_pkg::SHAPE_EMPTY && c == hcbd_pkg::CHAR_ZERO) ?
                   hcbd_pkg::SHAPE_ZERO : hcbd_pkg::SHAPE_OTHER;
      if (!digits_open) return;
      if (!is_hex) begin
         digits_open = 1'b0;
         return;
      end
      // The size saturates instead of wrapping.
      if (size_acc > ((SIZE_ALL_ONES - v32) >> 4)) begin
         size_acc = SIZE_ALL_ONES;
      end else begin
         size_acc = (size_acc << 4) + v32;
      end
   endfunction

   function automatic bit decode_byte(input hcbd_pkg::req_word_type w,
                                      output hcbd_pkg::rsp_word_type r);
      logic [7:0] c;
      c = w.data_byte;
      r = '0;
      if (w.new_message) clear_decoder();
      case (dec_phase)
         hcbd_pkg::PH_LINE: begin
            if (pending_cr) begin
               if (c == hcbd_pkg::CHAR_LF) begin
                  pending_cr = 1'b0;
                  if (line_shape == hcbd_pkg::SHAPE_ZERO) begin
                     dec_phase = hcbd_pkg::PH_DONE;
                     r.is_end  = 1'b1;
                     return 1'b1;
                  end
                  bytes_left = size_acc;
                  if (bytes_left == '0) begin
                     dec_phase = hcbd_pkg::PH_SKIP;
                     skip_left = hcbd_pkg::TRAIL_BYTES;
                  end else begin
                     dec_phase = hcbd_pkg::PH_DATA;
                  end
                  return 1'b0;
               end
               // A CR without LF is just another line character.
               pending_cr = 1'b0;
               add_line_char(hcbd_pkg::CHAR_CR);
            end
            if (c == hcbd_pkg::CHAR_CR) begin
               pending_cr = 1'b1;
            end else begin
               add_line_char(c);
            end
            return 1'b0;
         end
         hcbd_pkg::PH_DATA: begin
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == '0) begin
               dec_phase = hcbd_pkg::PH_SKIP;
               skip_left = hcbd_pkg::TRAIL_BYTES;
            end
            r.payload_byte = c;
            return 1'b1;
         end
         hcbd_pkg::PH_SKIP: begin
            skip_left = skip_left - 2'd1;
            if (skip_left == 2'd0) begin
               restart_line();
               bytes_left = '0;
            end
            return 1'b0;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic stim_row_type mk_row(input logic [7:0] b, input logic nm,
                                           input check_mode_type m,
                                           input logic [7:0] pb = 8'h00,
                                           input logic e = 1'b0);
      stim_row_type r;
      r.word.data_byte        = b;
      r.word.new_message      = nm;
      r.mode                  = m;
      r.fixed_word.payload_byte = pb;
      r.fixed_word.is_end     = e;
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return hcbd_pkg::CHAR_ZERO + 8'(n);
      return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      hcbd_pkg::req_word_type w;
      w.data_byte   = b;
      w.new_message = 1'b0;
      msg_words.push_back(w);
   endfunction

   // Writes a size line for the given value, with optional leading zeros and extension.
   function automatic void put_size_line(input logic [31:0] value, input int pad);
      int digits;
      bit upper;
      digits = 1;
      while (digits < 8 && (value >> (4 * digits)) != 0) digits++;
      digits += pad;
      upper = 1'($urandom_range(0, 1));
      for (int i = digits - 1; i >= 0; i--) begin
         put_byte(hex_char(4'((value >> (4 * i)) & 32'hF), upper));
      end
      if ($urandom_range(0, 4) == 0) begin
         put_byte(";");
         put_byte("n");
         put_byte("=");
         put_byte("1");
      end
      put_byte(hcbd_pkg::CHAR_CR);
      put_byte(hcbd_pkg::CHAR_LF);
   endfunction

   // Builds one random message: mostly well-formed chunk sequences, some noise.
   function automatic void build_message();
      int          kind;
      logic [31:0] size;
      msg_words.delete();
      tail_words.delete();
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
         repeat ($urandom_range(1, 4)) begin
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            put_size_line(size, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
            repeat (size) put_byte(8'($urandom()));
            // The two bytes after the payload are not checked by the block.
            if ($urandom_range(0, 9) == 0) begin
               put_byte(8'($urandom()));
               put_byte(8'($urandom()));
            end else begin
               put_byte(hcbd_pkg::CHAR_CR);
               put_byte(hcbd_pkg::CHAR_LF);
            end
         end
         if ($urandom_range(0, 9) != 0) begin
            put_byte(hcbd_pkg::CHAR_ZERO);
            put_byte(hcbd_pkg::CHAR_CR);
            put_byte(hcbd_pkg::CHAR_LF);
            repeat ($urandom_range(0, 3)) tail_words.push_back({8'($urandom()), 1'b0});
         end
      end else if (kind < 92) begin
         // Malformed size lines: zeros, lone CRs, non-hex characters.
         repeat ($urandom_range(1, 5)) begin
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 5))
                  0, 1:    put_byte(hcbd_pkg::CHAR_ZERO);
                  2:       put_byte(hcbd_pkg::CHAR_CR);
                  3:       put_byte(hex_char(4'($urandom()), 1'($urandom())));
                  4:       put_byte(" ");
                  default: put_byte(8'($urandom()));
               endcase
            end
            put_byte(hcbd_pkg::CHAR_CR);
            put_byte(hcbd_pkg::CHAR_LF);
            repeat ($urandom_range(0, 12)) put_byte(8'($urandom()));
         end
      end else if (kind < 97) begin
         // Oversized chunk size, cut short by the next message.
         put_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom())));
         repeat ($urandom_range(8, 11)) put_byte(hex_char(4'($urandom()), 1'($urandom())));
         put_byte(hcbd_pkg::CHAR_CR);
         put_byte(hcbd_pkg::CHAR_LF);
         repeat ($urandom_range(1, 10)) put_byte(8'($urandom()));
      end else begin
         repeat ($urandom_range(1, 30)) begin
            put_byte(8'($urandom()));
            if ($urandom_range(0, 15) == 0) msg_words[msg_words.size() - 1].new_message = 1'b1;
         end
      end
      msg_words[0].new_message = 1'b1;
   endfunction

   function automatic int pick_gap(input bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic void report(input string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endfunction

   // Offers one word after an optional gap and records what it should produce.
   task automatic offer_word(input hcbd_pkg::req_word_type w, input check_mode_type m,
                             input hcbd_pkg::rsp_word_type fixed, input int gap);
      bit                     has;
      hcbd_pkg::rsp_word_type r;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      has = decode_byte(w, r);
      case (m)
         CHECK_MODEL: if (has) awaited_words.push_back(r);
         CHECK_WORD:  awaited_words.push_back(fixed);
         default:     ;
      endcase
   endtask

   // The sender stops until every awaited word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_words.size() != 0);
   endtask

   // Sender: directed table first, then random messages.
   initial begin
      int items_sent;
      int msg_count;
      int burst_msgs;
      items_sent = 0;
      msg_count  = 0;
      burst_msgs = 0;
      clear_decoder();
      directed_rows = '{
         // A one-byte chunk carrying the largest byte value.
         mk_row("1", 1'b1, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_CR, 1'b0, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_LF, 1'b0, CHECK_MODEL),
         mk_row(8'hFF, 1'b0, CHECK_WORD, 8'hFF, 1'b0),
         // Trailing bytes are skipped whatever their value.
         mk_row("x", 1'b0, CHECK_MODEL),
         mk_row(8'hFF, 1'b0, CHECK_MODEL),
         // Empty size line: size zero, nothing forwarded.
         mk_row(hcbd_pkg::CHAR_CR, 1'b0, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_LF, 1'b0, CHECK_NONE),
         // A new message during the skip; "00" is zero but not the end.
         mk_row(hcbd_pkg::CHAR_ZERO, 1'b1, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_ZERO, 1'b0, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_CR, 1'b0, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_LF, 1'b0, CHECK_NONE),
         // Nine hex digits saturate the size.
         mk_row("F", 1'b1, CHECK_MODEL),
         mk_row("f", 1'b0, CHECK_MODEL),
         mk_row("F", 1'b0, CHECK_MODEL),
         mk_row("e", 1'b0, CHECK_MODEL),
         mk_row("9", 1'b0, CHECK_MODEL),
         mk_row("A", 1'b0, CHECK_MODEL),
         mk_row("0", 1'b0, CHECK_MODEL),
         mk_row("d", 1'b0, CHECK_MODEL),
         mk_row("B", 1'b0, CHECK_MODEL),
         // A lone CR closes the digits; the digit after it does not count.
         mk_row(hcbd_pkg::CHAR_CR, 1'b0, CHECK_MODEL),
         mk_row("3", 1'b0, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_CR, 1'b0, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_LF, 1'b0, CHECK_MODEL),
         mk_row(8'h00, 1'b0, CHECK_WORD, 8'h00, 1'b0),
         mk_row(8'h7F, 1'b0, CHECK_MODEL),
         // New message cuts the long chunk short and ends at once.
         mk_row(hcbd_pkg::CHAR_ZERO, 1'b1, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_CR, 1'b0, CHECK_MODEL),
         mk_row(hcbd_pkg::CHAR_LF, 1'b0, CHECK_WORD, 8'h00, 1'b1),
         // Bytes after the end are ignored.
         mk_row(8'hA5, 1'b0, CHECK_NONE)
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         offer_word(directed_rows[i].word, directed_rows[i].mode,
                    directed_rows[i].fixed_word, pick_gap(1'b0));
      end
      drain_results();

      while (items_sent < RANDOM_ITEMS) begin
         build_message();
         // Now and then ask the receiver for a long hold while words keep coming.
         if (msg_count % 8 == 3) begin
            hold_requests++;
            burst_msgs = 2;
         end else if (burst_msgs == 0 && $urandom_range(0, 3) == 0) begin
            burst_msgs = 1;
         end
         foreach (msg_words[k]) begin
            offer_word(msg_words[k], CHECK_MODEL, '0, pick_gap(burst_msgs != 0));
         end
         foreach (tail_words[k]) begin
            offer_word(tail_words[k], CHECK_MODEL, '0, pick_gap(burst_msgs != 0));
         end
         items_sent += msg_words.size();
         if (burst_msgs != 0) burst_msgs--;
         if (msg_count % 6 == 5) drain_results();
         msg_count++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("http_chunked_body_decoder test passed");
      end else begin
         $display("http_chunked_body_decoder test failed");
      end
      $finish;
   end

   // Receiver: random stalls, free-running stretches and requested long holds.
   initial begin
      int holds_done;
      int r;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            rsp_stall <= 1'b1;
            repeat ($urandom_range(60, 100)) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end else if (r < 65) begin
               rsp_stall <= 1'b0;
               @(posedge clock);
            end else if (r < 90) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else if (r < 98) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(4, 12)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(25, 50)) @(posedge clock);
            end
         end
      end
   end

   // Each accepted result word is compared with the oldest awaited word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_words.size() == 0) begin
            report($sformatf("unexpected word: payload_byte=%02h is_end=%0b",
                             rsp_word.payload_byte, rsp_word.is_end));
         end else begin
            want = awaited_words.pop_front();
            if (rsp_word.payload_byte !== want.payload_byte ||
                rsp_word.is_end !== want.is_end) begin
               report($sformatf("mismatch: expected payload_byte=%02h is_end=%0b, got %02h %0b",
                                want.payload_byte, want.is_end,
                                rsp_word.payload_byte, rsp_word.is_end));
            end
         end
      end
   end

   // Ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("http_chunked_body_decoder test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
